// ===== hw/rtl/mcdl_pkg.sv =====
package mcdl_pkg;

  // default sizing
  localparam int DEPTH_DEF       = 65536;
  localparam int SAMPLE_BITS_DEF = 24;

  // fixed field widths
  localparam int TARGET_BITS   = 32;
  localparam int COEF_BITS     = 16;
  localparam int OFFSET_BITS   = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 1;

  // delay fraction bits of the smoothed delay
  localparam int DLY_FRAC_BITS = 24;

  // rounding constant for a 16-bit right shift
  localparam int ROUND_HALF = 32768;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_TARGET = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF   = 1'd1;

  // register reset values
  localparam logic [TARGET_BITS-1:0] TARGET_RESET = 32'd65536;
  localparam logic [COEF_BITS-1:0]   COEF_RESET   = 16'd544;

  // sequencer states
  typedef enum logic [16:0] {
    S_CLR  = 17'd1 << 0,
    S_IDLE = 17'd1 << 1,
    S_SMTH = 17'd1 << 2,
    S_EFF  = 17'd1 << 3,
    S_BASE = 17'd1 << 4,
    S_RD0  = 17'd1 << 5,
    S_RD1  = 17'd1 << 6,
    S_RD2  = 17'd1 << 7,
    S_RD3  = 17'd1 << 8,
    S_CO   = 17'd1 << 9,
    S_M1   = 17'd1 << 10,
    S_A1   = 17'd1 << 11,
    S_M2   = 17'd1 << 12,
    S_A2   = 17'd1 << 13,
    S_M3   = 17'd1 << 14,
    S_A3   = 17'd1 << 15,
    S_OUT  = 17'd1 << 16
  } state_t;

endpackage

// ===== hw/rtl/modulated_cubic_delay_line.sv =====
// a request is taken only in idle; the smoothing, read and multiply-add states
//   then run until S_OUT registers the result; one shared multiplier handles the
//   delay smoothing and three interpolation steps, four reads share one ram port
// reset: synchronous; afterwards a clearing pass zeroes the ring
//   with sample_stall held high; configuration writes are taken meanwhile
module modulated_cubic_delay_line #(
  parameter int DEPTH       = mcdl_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = mcdl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample,
  input  logic signed [mcdl_pkg::OFFSET_BITS-1:0] mod_offset,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [SAMPLE_BITS-1:0]         out_sample,
  input  logic                                  cfg_write,
  input  logic [mcdl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [mcdl_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int DW = AW + mcdl_pkg::DLY_FRAC_BITS;
  localparam int CW = (DW > 40) ? DW : 40;
  localparam int EW = CW + 2;
  localparam int TW = SAMPLE_BITS + 6;
  localparam int MW = ((DW + 1) > TW) ? (DW + 1) : TW;
  localparam int FB = mcdl_pkg::COEF_BITS;

  localparam logic [DW-1:0] DLY_LO = DW'(1) << mcdl_pkg::DLY_FRAC_BITS;
  localparam logic [DW-1:0] DLY_HI = DW'(DEPTH - 3) << mcdl_pkg::DLY_FRAC_BITS;
  localparam logic signed [MW-1:0] SMAX = $signed(MW'({(SAMPLE_BITS-1){1'b1}}));
  localparam logic signed [MW-1:0] SMIN = ~SMAX;

  mcdl_pkg::state_t state;

  logic [mcdl_pkg::TARGET_BITS-1:0] target_delay;
  logic [mcdl_pkg::COEF_BITS-1:0]   smoothing_coef;
  logic [DW-1:0]                    cur;
  logic [AW-1:0]                    wp;
  logic [AW-1:0]                    clr_addr;

  logic signed [mcdl_pkg::OFFSET_BITS-1:0] mod_r;
  logic [AW+15:0]                   d16;
  logic [AW-1:0]                    base;
  logic [FB-1:0]                    frac;
  logic signed [SAMPLE_BITS-1:0]    y0, y1, y2;
  logic signed [MW-1:0]             t, a1, a2, a3;

  logic                   mem_we;
  logic [AW-1:0]          mem_addr;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic [SAMPLE_BITS-1:0] mem_rdata;

  logic signed [MW-1:0] mul_a;
  logic [FB-1:0]        mul_b;
  logic signed [MW-1:0] mul_add;
  logic signed [MW-1:0] mul_res;

  logic accept;
  assign sample_stall = (state != mcdl_pkg::S_IDLE);
  assign accept       = sample_valid && !sample_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_delay   <= mcdl_pkg::TARGET_RESET;
      smoothing_coef <= mcdl_pkg::COEF_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mcdl_pkg::REG_TARGET: target_delay   <= cfg_data;
        mcdl_pkg::REG_COEF:   smoothing_coef <= cfg_data[mcdl_pkg::COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamped target and distance to it
  logic [CW-1:0]      tgt_w;
  logic [DW-1:0]      tgt_c;
  logic signed [DW:0] diff;
  assign tgt_w = CW'({target_delay, 8'd0});
  always_comb begin
    if (tgt_w < CW'(DLY_LO)) begin
      tgt_c = DLY_LO;
    end else if (tgt_w > CW'(DLY_HI)) begin
      tgt_c = DLY_HI;
    end else begin
      tgt_c = tgt_w[DW-1:0];
    end
  end
  assign diff = $signed({1'b0, tgt_c}) - $signed({1'b0, cur});

  // effective delay, clamped, rounded to 16 fraction bits
  logic signed [EW-1:0] cur_e, mod_e, eff;
  logic [DW-1:0]        eff_c;
  logic [DW-1:0]        eff_rnd;
  assign cur_e = $signed({{(EW-DW){1'b0}}, cur});
  assign mod_e = EW'(mod_r);
  assign eff   = cur_e + (mod_e <<< 8);
  always_comb begin
    if (eff < $signed({{(EW-DW){1'b0}}, DLY_LO})) begin
      eff_c = DLY_LO;
    end else if (eff > $signed({{(EW-DW){1'b0}}, DLY_HI})) begin
      eff_c = DLY_HI;
    end else begin
      eff_c = eff[DW-1:0];
    end
  end
  assign eff_rnd = eff_c + DW'(128);

  // interpolation coefficients from the four neighbors
  logic signed [MW-1:0] ye0, ye1, ye2, ye3;
  assign ye0 = MW'(y0);
  assign ye1 = MW'(y1);
  assign ye2 = MW'(y2);
  assign ye3 = MW'($signed(mem_rdata));

  // final halving with saturation
  logic signed [MW-1:0] t_half;
  logic [SAMPLE_BITS-1:0] sat;
  assign t_half = (t + $signed(MW'(1))) >>> 1;
  always_comb begin
    if (t_half > SMAX) begin
      sat = SMAX[SAMPLE_BITS-1:0];
    end else if (t_half < SMIN) begin
      sat = SMIN[SAMPLE_BITS-1:0];
    end else begin
      sat = t_half[SAMPLE_BITS-1:0];
    end
  end

  // ring port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = base;
    mem_wdata = in_sample;
    case (state)
      mcdl_pkg::S_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      mcdl_pkg::S_IDLE: begin
        mem_we   = accept;
        mem_addr = wp;
      end
      mcdl_pkg::S_RD0: mem_addr = base - AW'(1);
      mcdl_pkg::S_RD1: mem_addr = base;
      mcdl_pkg::S_RD2: mem_addr = base + AW'(1);
      mcdl_pkg::S_RD3: mem_addr = base + AW'(2);
      default: ;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a   = t;
    mul_b   = frac;
    mul_add = a1;
    case (state)
      mcdl_pkg::S_IDLE: begin
        mul_a = MW'(diff);
        mul_b = smoothing_coef;
      end
      mcdl_pkg::S_SMTH: mul_add = $signed({{(MW-DW){1'b0}}, cur});
      mcdl_pkg::S_A2:   mul_add = a2;
      mcdl_pkg::S_A3:   mul_add = a3;
      default: ;
    endcase
  end

  mcdl_ring #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  mcdl_mul #(
    .MW (MW)
  ) u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .addend (mul_add),
    .res    (mul_res)
  );

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mcdl_pkg::S_CLR;
      clr_addr     <= '0;
      wp           <= '0;
      cur          <= DLY_LO;
      result_valid <= 1'b0;
    end else begin
      // result valid: a new result wins over the one being taken
      if (state == mcdl_pkg::S_OUT && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        mcdl_pkg::S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == {AW{1'b1}}) begin
            state <= mcdl_pkg::S_IDLE;
          end
        end
        mcdl_pkg::S_IDLE: begin
          if (accept) begin
            state <= mcdl_pkg::S_SMTH;
          end
        end
        mcdl_pkg::S_SMTH: begin
          cur   <= mul_res[DW-1:0];
          state <= mcdl_pkg::S_EFF;
        end
        mcdl_pkg::S_EFF:  state <= mcdl_pkg::S_BASE;
        mcdl_pkg::S_BASE: state <= mcdl_pkg::S_RD0;
        mcdl_pkg::S_RD0:  state <= mcdl_pkg::S_RD1;
        mcdl_pkg::S_RD1:  state <= mcdl_pkg::S_RD2;
        mcdl_pkg::S_RD2:  state <= mcdl_pkg::S_RD3;
        mcdl_pkg::S_RD3:  state <= mcdl_pkg::S_CO;
        mcdl_pkg::S_CO:   state <= mcdl_pkg::S_M1;
        mcdl_pkg::S_M1:   state <= mcdl_pkg::S_A1;
        mcdl_pkg::S_A1:   state <= mcdl_pkg::S_M2;
        mcdl_pkg::S_M2:   state <= mcdl_pkg::S_A2;
        mcdl_pkg::S_A2:   state <= mcdl_pkg::S_M3;
        mcdl_pkg::S_M3:   state <= mcdl_pkg::S_A3;
        mcdl_pkg::S_A3:   state <= mcdl_pkg::S_OUT;
        mcdl_pkg::S_OUT: begin
          if (!result_valid || !result_stall) begin
            wp    <= wp + AW'(1);
            state <= mcdl_pkg::S_IDLE;
          end
        end
        default: state <= mcdl_pkg::S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      mcdl_pkg::S_IDLE: mod_r <= mod_offset;
      mcdl_pkg::S_EFF:  d16   <= eff_rnd[DW-1:8];
      mcdl_pkg::S_BASE: begin
        // a nonzero fraction steps one sample further back
        base <= wp - d16[AW+15:16] - AW'(d16[15:0] != '0);
        frac <= FB'(0) - d16[15:0];
      end
      mcdl_pkg::S_RD1: y0 <= $signed(mem_rdata);
      mcdl_pkg::S_RD2: y1 <= $signed(mem_rdata);
      mcdl_pkg::S_RD3: y2 <= $signed(mem_rdata);
      mcdl_pkg::S_CO: begin
        t  <= -ye0 + (ye1 <<< 1) + ye1 - (ye2 <<< 1) - ye2 + ye3;
        a1 <= (ye0 <<< 1) - (ye1 <<< 2) - ye1 + (ye2 <<< 2) - ye3;
        a2 <= ye2 - ye0;
        a3 <= ye1 <<< 1;
      end
      mcdl_pkg::S_A1: t <= mul_res;
      mcdl_pkg::S_A2: t <= mul_res;
      mcdl_pkg::S_A3: t <= mul_res;
      mcdl_pkg::S_OUT: begin
        if (!result_valid || !result_stall) begin
          out_sample <= sat;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/mcdl_ring.sv =====
module mcdl_ring #(
  parameter int DEPTH       = mcdl_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = mcdl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [SAMPLE_BITS-1:0]   wdata,
  output logic [SAMPLE_BITS-1:0]   rdata
);

  logic [SAMPLE_BITS-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/mcdl_mul.sv =====
module mcdl_mul #(
  parameter int MW = 41
) (
  input  logic                             clk,
  input  logic signed [MW-1:0]             a,
  input  logic        [mcdl_pkg::COEF_BITS-1:0] b,
  input  logic signed [MW-1:0]             addend,
  output logic signed [MW-1:0]             res
);

  localparam int PW = MW + mcdl_pkg::COEF_BITS + 1;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rsum;
  logic signed [PW-1:0] rsh;

  // signed by unsigned product, registered
  always_ff @(posedge clk) begin
    prod <= a * $signed({1'b0, b});
  end

  // round half up, drop 16 bits, then add
  assign rsum = prod + $signed(PW'(mcdl_pkg::ROUND_HALF));
  assign rsh  = rsum >>> mcdl_pkg::COEF_BITS;
  assign res  = $signed(rsh[MW-1:0]) + addend;

endmodule

// ===== tb/sv/modulated_cubic_delay_line_tb.sv =====
module modulated_cubic_delay_line_tb;

  localparam int DEPTH          = mcdl_pkg::DEPTH_DEF;
  localparam int SBITS          = mcdl_pkg::SAMPLE_BITS_DEF;
  localparam int ADDR_BITS      = $clog2(DEPTH);
  localparam int N_PHASES       = 8;
  localparam int PHASE_ITEMS    = 225;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 4 * DEPTH + 10000;

  // delay range in Q16.24
  localparam longint DLY_MIN = longint'(1) <<< mcdl_pkg::DLY_FRAC_BITS;
  localparam longint DLY_MAX = longint'(DEPTH - 3) <<< mcdl_pkg::DLY_FRAC_BITS;

  localparam logic signed [SBITS-1:0] SMP_MAX = {1'b0, {(SBITS-1){1'b1}}};
  localparam logic signed [SBITS-1:0] SMP_MIN = {1'b1, {(SBITS-1){1'b0}}};

  typedef struct {
    bit                                      is_cfg;
    logic [mcdl_pkg::CFG_IDX_BITS-1:0]       idx;
    logic [mcdl_pkg::CFG_DATA_BITS-1:0]      val;
    logic signed [SBITS-1:0]                 smp;
    logic signed [mcdl_pkg::OFFSET_BITS-1:0] ofs;
    bit                                      typed;
    logic signed [SBITS-1:0]                 want;
  } plan_row_t;

  logic                                    clk = 1'b0;
  logic                                    rst = 1'b1;
  logic                                    sample_valid = 1'b0;
  logic                                    sample_stall;
  logic signed [SBITS-1:0]                 in_sample = '0;
  logic signed [mcdl_pkg::OFFSET_BITS-1:0] mod_offset = '0;
  logic                                    result_valid;
  logic                                    result_stall = 1'b0;
  logic signed [SBITS-1:0]                 out_sample;
  logic                                    cfg_write = 1'b0;
  logic [mcdl_pkg::CFG_IDX_BITS-1:0]       cfg_index = mcdl_pkg::REG_TARGET;
  logic [mcdl_pkg::CFG_DATA_BITS-1:0]      cfg_data = '0;

  // typed expectation travels with the request
  bit                              drive_typed = 1'b0;
  logic signed [SBITS-1:0]         drive_want = '0;

  bit                              tx_idle_on = 1'b1;
  bit                              rx_idle_on = 1'b1;
  int                              rx_wait = 0;
  int                              rx_draw;
  int                              quiet_cycles = 0;
  int                              errors = 0;

  // delay line shadow state
  logic signed [SBITS-1:0]         ring [DEPTH];
  logic [ADDR_BITS-1:0]            wr_ptr;
  longint                          smooth_dly;
  longint                          tgt_set;
  longint                          coef_set;
  logic signed [SBITS-1:0]         pending_outputs [$];
  logic signed [SBITS-1:0]         predicted;
  logic signed [SBITS-1:0]         oldest;
  plan_row_t                       directed_plan [$];

  modulated_cubic_delay_line i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .in_sample    (in_sample),
    .mod_offset   (mod_offset),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_sample   (out_sample),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor((x + half) / 2^16)
  function automatic longint round_shift16(longint x);
    return (x + mcdl_pkg::ROUND_HALF) >>> 16;
  endfunction

  function automatic void reset_model();
    foreach (ring[i]) ring[i] = '0;
    wr_ptr     = '0;
    tgt_set    = longint'(mcdl_pkg::TARGET_RESET);
    coef_set   = longint'(mcdl_pkg::COEF_RESET);
    smooth_dly = longint'(mcdl_pkg::TARGET_RESET) <<< (mcdl_pkg::DLY_FRAC_BITS - 16);
  endfunction

  // write, smooth the delay, read four taps and interpolate
  function automatic logic signed [SBITS-1:0] delay_line_step(
    logic signed [SBITS-1:0] smp, logic signed [mcdl_pkg::OFFSET_BITS-1:0] ofs);
    longint goal, eff, d16, di, frac, base, ofs_l, lim;
    longint y0, y1, y2, y3, t;
    ring[wr_ptr] = smp;

    goal = tgt_set <<< (mcdl_pkg::DLY_FRAC_BITS - 16);
    if (goal < DLY_MIN) goal = DLY_MIN;
    if (goal > DLY_MAX) goal = DLY_MAX;
    smooth_dly = smooth_dly + round_shift16((goal - smooth_dly) * coef_set);

    ofs_l = longint'(ofs);
    eff = smooth_dly + ofs_l * 256;
    if (eff < DLY_MIN) eff = DLY_MIN;
    if (eff > DLY_MAX) eff = DLY_MAX;
    d16  = (eff + 128) >>> 8;
    di   = d16 >>> 16;
    frac = d16 & 65535;
    base = longint'(wr_ptr) - di;
    if (frac != 0) begin
      base = base - 1;
      frac = 65536 - frac;
    end

    y0 = longint'(ring[ADDR_BITS'(base - 1)]);
    y1 = longint'(ring[ADDR_BITS'(base)]);
    y2 = longint'(ring[ADDR_BITS'(base + 1)]);
    y3 = longint'(ring[ADDR_BITS'(base + 2)]);

    // horner form on doubled catmull-rom coefficients
    t = -y0 + 3 * y1 - 3 * y2 + y3;
    t = round_shift16(t * frac) + (2 * y0 - 5 * y1 + 4 * y2 - y3);
    t = round_shift16(t * frac) + (y2 - y0);
    t = round_shift16(t * frac) + 2 * y1;
    t = (t + 1) >>> 1;

    lim = longint'(1) <<< (SBITS - 1);
    if (t > lim - 1) t = lim - 1;
    if (t < -lim) t = -lim;
    wr_ptr = wr_ptr + 1'b1;
    return t[SBITS-1:0];
  endfunction

  function automatic void add_item(logic signed [SBITS-1:0] smp,
                                   logic signed [mcdl_pkg::OFFSET_BITS-1:0] ofs,
                                   bit typed, logic signed [SBITS-1:0] want);
    plan_row_t r;
    r = '{default: '0};
    r.smp   = smp;
    r.ofs   = ofs;
    r.typed = typed;
    r.want  = want;
    directed_plan.push_back(r);
  endfunction

  function automatic void add_cfg(logic [mcdl_pkg::CFG_IDX_BITS-1:0] idx,
                                  logic [mcdl_pkg::CFG_DATA_BITS-1:0] val);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    directed_plan.push_back(r);
  endfunction

  function automatic logic signed [SBITS-1:0] rand_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      default: return r[SBITS-1:0];
    endcase
  endfunction

  // mostly small offsets around the current delay, some whole samples, some anything
  function automatic logic signed [mcdl_pkg::OFFSET_BITS-1:0] rand_offset();
    int n;
    case ($urandom_range(0, 19))
      0, 1, 2: return $urandom;
      3, 4: begin
        n = $urandom_range(0, 16);
        return (n - 8) <<< 16;
      end
      default: begin
        n = $urandom_range(0, 16 * 65536);
        return n - 8 * 65536;
      end
    endcase
  endfunction

  function automatic logic [mcdl_pkg::TARGET_BITS-1:0] pick_target();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return mcdl_pkg::TARGET_RESET;
      3:       return $urandom;
      default: return ($urandom_range(1, 40) << 16) | $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic logic [mcdl_pkg::COEF_BITS-1:0] pick_coef();
    logic [31:0] r;
    r = $urandom_range(1, 65535);
    case ($urandom_range(0, 5))
      0:       return 16'd1;
      1:       return 16'hFFFF;
      2:       return mcdl_pkg::COEF_RESET;
      3:       return 16'd0;
      default: return r[mcdl_pkg::COEF_BITS-1:0];
    endcase
  endfunction

  task automatic write_reg(logic [mcdl_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [mcdl_pkg::CFG_DATA_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // one sample request, held until taken
  task automatic send_request(logic signed [SBITS-1:0] smp,
                              logic signed [mcdl_pkg::OFFSET_BITS-1:0] ofs,
                              bit typed, logic signed [SBITS-1:0] want);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    in_sample    <= smp;
    mod_offset   <= ofs;
    drive_typed  <= typed;
    drive_want   <= want;
    do @(posedge clk); while (sample_stall);
  endtask

  // drain all outputs, then let the pipeline go quiet
  task automatic settle();
    sample_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // predict on accepted requests, check accepted outputs
  always @(posedge clk) begin
    if (rst) begin
      reset_model();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          mcdl_pkg::REG_TARGET: tgt_set = longint'(cfg_data);
          mcdl_pkg::REG_COEF:   coef_set = longint'(cfg_data[mcdl_pkg::COEF_BITS-1:0]);
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) begin
        predicted = delay_line_step(in_sample, mod_offset);
        pending_outputs.push_back(drive_typed ? drive_want : predicted);
      end
      if (result_valid && !result_stall) begin
        if (pending_outputs.size() == 0) begin
          errors++;
          $display("%0t: unexpected out_sample, expected none, actual %0d",
                   $time, out_sample);
        end else begin
          oldest = pending_outputs.pop_front();
          if (out_sample !== oldest) begin
            errors++;
            $display("%0t: out_sample mismatch, expected %0d, actual %0d",
                     $time, oldest, out_sample);
          end
        end
      end
    end
  end

  // output side back-pressure, counted while a result waits
  always @(posedge clk) begin
    if (rst) begin
      rx_wait      <= 4;
      result_stall <= 1'b1;
    end else if (result_valid && !result_stall) begin
      rx_draw = rx_idle_on ? $urandom_range(0, 11) : 0;
      rx_wait      <= rx_draw;
      result_stall <= (rx_draw != 0);
    end else if (result_valid && rx_wait != 0) begin
      rx_wait      <= rx_wait - 1;
      result_stall <= (rx_wait != 1);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    plan_row_t row;
    int ph;
    int k;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // one-sample delay right after reset passes the previous sample through
    add_item(SMP_MAX, 32'h0, 1'b1, '0);
    add_item(SMP_MIN, 32'h0, 1'b1, SMP_MAX);
    add_item('1, 32'h0, 1'b1, SMP_MIN);
    add_item('0, 32'h0, 1'b1, '1);
    // huge offsets clamp to the far end (never written) and to one sample
    add_item(24'h123456, 32'h7FFF_FFFF, 1'b1, '0);
    add_item(24'h654321, 32'h8000_0000, 1'b1, 24'h123456);
    // fractional reads over full-scale swings, saturation likely
    add_item(SMP_MAX, 32'h0000_8000, 1'b0, '0);
    add_item(SMP_MIN, 32'h0000_4000, 1'b0, '0);
    add_item(SMP_MAX, 32'h0000_C000, 1'b0, '0);
    add_item(SMP_MIN, 32'h0001_8000, 1'b0, '0);
    add_item(SMP_MAX, 32'h0000_FFFF, 1'b0, '0);
    add_item(24'h000001, 32'h0000_0001, 1'b0, '0);
    // fastest smoothing toward a target above the range, upper data bits ignored
    add_cfg(mcdl_pkg::REG_COEF, 32'hA5A5_FFFF);
    add_cfg(mcdl_pkg::REG_TARGET, 32'hFFFF_FFFF);
    add_item(24'h2AAAAA, 32'h0, 1'b0, '0);
    add_item(24'hD55556, 32'hFFFF_0000, 1'b0, '0);
    add_item(24'h7F0000, 32'hFFFE_2000, 1'b0, '0);
    // target below the floor
    add_cfg(mcdl_pkg::REG_TARGET, 32'h0);
    add_item(24'h0F0F0F, 32'h0002_0000, 1'b0, '0);
    add_item(24'hF0F0F0, 32'h0000_3000, 1'b0, '0);
    // zero coefficient freezes the delay
    add_cfg(mcdl_pkg::REG_COEF, 32'h0);
    add_cfg(mcdl_pkg::REG_TARGET, 32'h0010_0000);
    add_item(24'h333333, 32'h0, 1'b0, '0);
    add_item(24'hCCCCCC, 32'h0003_0000, 1'b0, '0);
    // slowest coefficient, target two samples below the upper clamp
    add_cfg(mcdl_pkg::REG_COEF, 32'h1);
    add_cfg(mcdl_pkg::REG_TARGET, 32'hFFFB_0000);
    add_item(24'h400000, 32'h0, 1'b0, '0);
    add_item(24'hC00000, 32'h0000_0100, 1'b0, '0);
    // back to reset smoothing, fractional target
    add_cfg(mcdl_pkg::REG_COEF, {16'd0, mcdl_pkg::COEF_RESET});
    add_cfg(mcdl_pkg::REG_TARGET, 32'h0002_8000);
    add_item(SMP_MAX, 32'h0, 1'b0, '0);
    add_item(SMP_MIN, 32'h0, 1'b0, '0);
    add_item(SMP_MAX, 32'hFFFF_C000, 1'b0, '0);

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.is_cfg) begin
        settle();
        write_reg(row.idx, row.val);
      end else begin
        send_request(row.smp, row.ofs, row.typed, row.want);
      end
    end

    // random phases, each with its own settings and idle pattern
    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      tx_idle_on <= (ph % 2 == 0);
      rx_idle_on <= (ph % 4 < 2);
      write_reg(mcdl_pkg::REG_COEF, {16'($urandom), pick_coef()});
      write_reg(mcdl_pkg::REG_TARGET, pick_target());
      for (k = 0; k < PHASE_ITEMS; k++) begin
        send_request(rand_sample(), rand_offset(), 1'b0, '0);
      end
    end

    settle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
